[src/olar_pkg.sv]
// Types and codes shared by the ordered list block.
// No dependencies; imported by olar_cell and ordered_list_append_remove.
package olar_pkg;

  localparam int VAL_W = 32;

  // request opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ENTRY    = 3'd4;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } olar_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } olar_rsp_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    append_en;
    logic                    remove_en;
    logic                    rotate_en;
    logic signed [VAL_W-1:0] value;
  } olar_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } olar_state_t;

endpackage

[src/olar_cell.sv]
// One storage cell of the list chain: holds one entry and takes its
// neighbor's entry on remove and list rotation. Depends on olar_pkg.
module olar_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic                             clk,
  input  olar_pkg::olar_ctl_t              ctl,
  input  logic [OCC_W-1:0]                 occ,
  input  logic signed [olar_pkg::VAL_W-1:0] right_data,
  input  logic signed [olar_pkg::VAL_W-1:0] head_data,
  input  logic                             found_in,
  output logic                             found_out,
  output logic signed [olar_pkg::VAL_W-1:0] data_out
);
  import olar_pkg::*;

  localparam logic [OCC_W-1:0] IDX_C  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] NEXT_C = OCC_W'(IDX + 1);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    in_list;
  logic                    match;

  // match only counts inside the occupied part of the chain
  assign in_list   = IDX_C < occ;
  assign match     = in_list && (data_r == ctl.value);
  assign found_out = found_in | match;
  assign data_out  = data_r;

  // next entry of this cell
  always_comb begin
    data_nxt = data_r;
    if (ctl.append_en && (IDX_C == occ)) begin
      data_nxt = ctl.value;
    end else if (ctl.remove_en && found_out) begin
      data_nxt = right_data;
    end else if (ctl.rotate_en) begin
      if (NEXT_C < occ) begin
        data_nxt = right_data;
      end else if (NEXT_C == occ) begin
        data_nxt = head_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[src/ordered_list_append_remove.sv]
// Top level of the ordered list: sequencer, occupancy count and result register.
// Depends on olar_pkg and olar_cell.
//
// Keeps up to DEPTH signed 32-bit values in a row of cells, head in cell 0.
// Append and remove take one request per cycle unless a list streams or the
// output stalls: every cell compares its entry with the request value at once,
// and on remove the cells from the first match onward load their right neighbor
// in the same cycle. A list request streams its entries from head to tail, one
// result per cycle unless the output stalls, with last on the final one; the
// chain rotates one place per result and is back in order when the list ends.
// An empty list gives one result with status empty. Results leave through one
// output register that takes a new result in the cycle the old one is taken.
module ordered_list_append_remove #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olar_pkg::olar_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olar_pkg::olar_rsp_t out_data
);
  import olar_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] ONE_C   = OCC_W'(1);

  olar_state_t state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  olar_rsp_t        out_data_r, out_data_nxt;

  olar_ctl_t               ctl;
  logic                    slot_free;
  logic                    accept;
  logic                    emit;
  logic                    found;
  logic [DEPTH:0]          found_w;
  logic signed [VAL_W-1:0] data_w [DEPTH+1];

  // cell chain
  assign found_w[0]   = 1'b0;
  assign data_w[DEPTH] = '0;
  assign found         = found_w[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    olar_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ_r),
      .right_data (data_w[i+1]),
      .head_data  (data_w[0]),
      .found_in   (found_w[i]),
      .found_out  (found_w[i+1]),
      .data_out   (data_w[i])
    );
  end

  // handshake
  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.opcode == OP_LIST) && (occ_r != '0)) begin
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        if (slot_free && (cnt_r == ONE_C)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    emit     = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = !slot_free;
      S_LIST: emit     = slot_free;
      default: begin
        in_stall = 1'b1;
        emit     = 1'b0;
      end
    endcase
  end

  // cell control
  always_comb begin
    ctl.value     = in_data.value;
    ctl.append_en = accept && (in_data.opcode == OP_APPEND) && (occ_r != DEPTH_C);
    ctl.remove_en = accept && (in_data.opcode == OP_REMOVE);
    ctl.rotate_en = emit;
  end

  // occupancy, list count and result register
  always_comb begin
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      case (in_data.opcode)
        OP_APPEND: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_DONE, entry_value: '0, last: 1'b1};
          if (occ_r == DEPTH_C) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            occ_nxt = occ_r + ONE_C;
          end
        end
        OP_REMOVE: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_DONE, entry_value: '0, last: 1'b1};
          if (occ_r == '0) begin
            out_data_nxt.status = ST_EMPTY;
          end else if (!found) begin
            out_data_nxt.status = ST_NOTFOUND;
          end else begin
            occ_nxt = occ_r - ONE_C;
          end
        end
        OP_LIST: begin
          if (occ_r == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ST_EMPTY, entry_value: '0, last: 1'b1};
          end else begin
            cnt_nxt = occ_r;
          end
        end
        default: ;
      endcase
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: ST_ENTRY, entry_value: data_w[0], last: cnt_r == ONE_C};
      cnt_nxt       = cnt_r - ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // occupancy stays within the chain
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C) else $error("occupancy beyond depth");

  // list count is live and bounded while streaming
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> ((cnt_r != '0) && (cnt_r <= occ_r)))
    else $error("list count out of range");

  // occupancy does not move while a list streams
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |=> (occ_r == $past(occ_r)))
    else $error("occupancy changed during list");

  // a successful append grows the list by one
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append_en |=> (occ_r == $past(occ_r) + ONE_C))
    else $error("append did not grow the list");

  // a result marked last while listing ends the list
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (cnt_r == ONE_C)) |=> (state_r == S_IDLE))
    else $error("list did not end on last entry");

endmodule
